FILE: rtl/ffea_pkg.sv
`timescale 1ns / 1ps

package ffea_pkg;

   // default sizing
   localparam int MEM_SIZE_DEFAULT    = 1024;
   localparam int MAX_EXTENTS_DEFAULT = 16;

   // field widths
   localparam int OPCODE_W = 1;
   localparam int START_W  = 10;
   localparam int LENGTH_W = 11;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 10;

   // start + length needs this many bits
   localparam int CALC_W_MIN = 12;

   localparam logic [OPCODE_W-1:0] OPC_ALLOC = 1'b0;
   localparam logic [OPCODE_W-1:0] OPC_FREE  = 1'b1;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_NOFIT = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // datapath micro-ops, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_READ,
      OP_READ_PREV,
      OP_NEXT,
      OP_SHRINK,
      OP_GRANT_DROP,
      OP_MARK_LO,
      OP_MERGE_START,
      OP_MERGE_EXT,
      OP_MERGE_WR,
      OP_DROP_WR,
      OP_DROP_END,
      OP_INS_START,
      OP_SHUP_WR,
      OP_INS_WR,
      OP_RSP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_status;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic trivial;
      logic at_end;
      logic fit_gt;
      logic fit_eq;
      logic lim_ge_s;
      logic first_le_e;
      logic full;
      logic idx_eq_lo;
   } dp_sts_type;

endpackage

FILE: rtl/ffea_req_if.sv
`timescale 1ns / 1ps

interface ffea_req_if;
   logic                               valid;
   logic                               ready;
   logic [ffea_pkg::OPCODE_W-1:0]      opcode;
   logic [ffea_pkg::START_W-1:0]       block_start;
   logic [ffea_pkg::LENGTH_W-1:0]      block_length;

   modport source (output valid, output opcode, output block_start, output block_length,
                   input ready);
   modport sink   (input valid, input opcode, input block_start, input block_length,
                   output ready);
endinterface

FILE: rtl/ffea_rsp_if.sv
`timescale 1ns / 1ps

interface ffea_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffea_pkg::STATUS_W-1:0] status;
   logic [ffea_pkg::GRANT_W-1:0]  granted_start;

   modport source (output valid, output status, output granted_start, input ready);
   modport sink   (input valid, input status, input granted_start, output ready);
endinterface

FILE: rtl/ffea_ctrl.sv
`timescale 1ns / 1ps

module ffea_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ffea_pkg::dp_cmd_type  cmd,
   input  ffea_pkg::dp_sts_type  sts
);

   typedef enum logic [15:0] {
      S_INIT     = 16'h0001,
      S_IDLE     = 16'h0002,
      S_DISPATCH = 16'h0004,
      S_A_FETCH  = 16'h0008,
      S_A_EVAL   = 16'h0010,
      S_DROP_RD  = 16'h0020,
      S_DROP_WR  = 16'h0040,
      S_LO_FETCH = 16'h0080,
      S_LO_EVAL  = 16'h0100,
      S_HI_FETCH = 16'h0200,
      S_HI_EVAL  = 16'h0400,
      S_MERGE_WR = 16'h0800,
      S_INS      = 16'h1000,
      S_SHUP_RD  = 16'h2000,
      S_SHUP_WR  = 16'h4000,
      S_RESP     = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;

   always_comb begin
      state_in       = state_ff;
      cmd.op         = ffea_pkg::OP_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = ffea_pkg::ST_DONE;
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.op   = ffea_pkg::OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ffea_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!sts.is_free) begin
               state_in = S_A_FETCH;
            end else if (sts.trivial) begin
               state_in = S_RESP;
            end else begin
               state_in = S_LO_FETCH;
            end
         end
         S_A_FETCH: begin
            if (sts.at_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = ffea_pkg::ST_NOFIT;
               state_in       = S_RESP;
            end else begin
               cmd.op   = ffea_pkg::OP_READ;
               state_in = S_A_EVAL;
            end
         end
         S_A_EVAL: begin
            if (sts.fit_gt) begin
               cmd.op   = ffea_pkg::OP_SHRINK;
               state_in = S_RESP;
            end else if (sts.fit_eq) begin
               cmd.op   = ffea_pkg::OP_GRANT_DROP;
               state_in = S_DROP_RD;
            end else begin
               cmd.op   = ffea_pkg::OP_NEXT;
               state_in = S_A_FETCH;
            end
         end
         S_DROP_RD: begin
            if (sts.at_end) begin
               cmd.op   = ffea_pkg::OP_DROP_END;
               state_in = S_RESP;
            end else begin
               cmd.op   = ffea_pkg::OP_READ;
               state_in = S_DROP_WR;
            end
         end
         S_DROP_WR: begin
            cmd.op   = ffea_pkg::OP_DROP_WR;
            state_in = S_DROP_RD;
         end
         S_LO_FETCH: begin
            if (sts.at_end) begin
               cmd.op   = ffea_pkg::OP_MARK_LO;
               state_in = S_INS;
            end else begin
               cmd.op   = ffea_pkg::OP_READ;
               state_in = S_LO_EVAL;
            end
         end
         S_LO_EVAL: begin
            if (sts.lim_ge_s) begin
               if (sts.first_le_e) begin
                  cmd.op   = ffea_pkg::OP_MERGE_START;
                  state_in = S_HI_FETCH;
               end else begin
                  cmd.op   = ffea_pkg::OP_MARK_LO;
                  state_in = S_INS;
               end
            end else begin
               cmd.op   = ffea_pkg::OP_NEXT;
               state_in = S_LO_FETCH;
            end
         end
         S_HI_FETCH: begin
            if (sts.at_end) begin
               state_in = S_MERGE_WR;
            end else begin
               cmd.op   = ffea_pkg::OP_READ;
               state_in = S_HI_EVAL;
            end
         end
         S_HI_EVAL: begin
            if (sts.first_le_e) begin
               cmd.op   = ffea_pkg::OP_MERGE_EXT;
               state_in = S_HI_FETCH;
            end else begin
               state_in = S_MERGE_WR;
            end
         end
         S_MERGE_WR: begin
            cmd.op   = ffea_pkg::OP_MERGE_WR;
            state_in = S_DROP_RD;
         end
         S_INS: begin
            if (sts.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ffea_pkg::ST_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.op   = ffea_pkg::OP_INS_START;
               state_in = S_SHUP_RD;
            end
         end
         S_SHUP_RD: begin
            if (sts.idx_eq_lo) begin
               cmd.op   = ffea_pkg::OP_INS_WR;
               state_in = S_RESP;
            end else begin
               cmd.op   = ffea_pkg::OP_READ_PREV;
               state_in = S_SHUP_WR;
            end
         end
         S_SHUP_WR: begin
            cmd.op   = ffea_pkg::OP_SHUP_WR;
            state_in = S_SHUP_RD;
         end
         S_RESP: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = ffea_pkg::OP_RSP_LOAD;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/ffea_dpath.sv
`timescale 1ns / 1ps

module ffea_dpath #(
   parameter int MEM_SIZE    = ffea_pkg::MEM_SIZE_DEFAULT,
   parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ffea_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ffea_pkg::START_W-1:0]  req_block_start,
   input  logic [ffea_pkg::LENGTH_W-1:0] req_block_length,
   output ffea_pkg::status_type          rsp_status,
   output logic [ffea_pkg::GRANT_W-1:0]  rsp_granted_start,
   input  ffea_pkg::dp_cmd_type          cmd,
   output ffea_pkg::dp_sts_type          sts
);

   localparam int AW = $clog2(MEM_SIZE + 1);             // extent bound width
   localparam int WW = (AW > ffea_pkg::CALC_W_MIN) ? AW : ffea_pkg::CALC_W_MIN;
   localparam int CW = $clog2(MAX_EXTENTS + 1);          // count / pointer width
   localparam int XW = $clog2(MAX_EXTENTS);              // memory address width
   localparam logic [AW-1:0] MEM_AW = AW'(MEM_SIZE);
   localparam logic [WW-1:0] MEM_WW = WW'(MEM_SIZE);

   // entry = {first, limit}
   logic [2*AW-1:0] extent_ff [MAX_EXTENTS];
   logic [2*AW-1:0] rd_data_ff;

   logic            wr_en;
   logic [XW-1:0]   wr_addr;
   logic [2*AW-1:0] wr_data;
   logic            rd_en;
   logic [XW-1:0]   rd_addr;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] dst_ff, dst_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [ffea_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [ffea_pkg::START_W-1:0]  s_ff, s_in;
   logic [ffea_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic [AW-1:0] e_ff, e_in;
   logic [AW-1:0] nf_ff, nf_in;
   logic [AW-1:0] nl_ff, nl_in;
   logic [AW-1:0] grant_ff, grant_in;
   ffea_pkg::status_type status_ff, status_in;
   ffea_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [ffea_pkg::GRANT_W-1:0] rsp_grant_ff, rsp_grant_in;

   logic [AW-1:0] rd_first, rd_limit;
   logic [WW-1:0] avail_w, len_w, s_w, sum_w, first_len_w, grant_w;
   logic [AW-1:0] s_aw, e_clip, first_plus_len, min_first, max_limit;
   logic [CW-1:0] idx_m1;

   assign rd_first = rd_data_ff[2*AW-1:AW];
   assign rd_limit = rd_data_ff[AW-1:0];

   assign len_w   = WW'(len_ff);
   assign s_w     = WW'(s_ff);
   assign s_aw    = s_w[AW-1:0];
   assign avail_w = WW'(rd_limit) - WW'(rd_first);
   assign first_len_w    = WW'(rd_first) + len_w;
   assign first_plus_len = first_len_w[AW-1:0];
   assign min_first = (rd_first < s_aw) ? rd_first : s_aw;
   assign max_limit = (rd_limit > e_ff) ? rd_limit : e_ff;
   assign idx_m1    = idx_ff - CW'(1);
   assign grant_w   = WW'(grant_ff);

   // end of the incoming range, clipped to the memory
   assign sum_w  = WW'(req_block_start) + WW'(req_block_length);
   assign e_clip = (sum_w > MEM_WW) ? MEM_AW : sum_w[AW-1:0];

   always_comb begin
      sts.is_free    = (op_ff == ffea_pkg::OPC_FREE);
      sts.trivial    = (len_ff == '0) || (s_w >= MEM_WW);
      sts.at_end     = (idx_ff == count_ff);
      sts.fit_gt     = (avail_w > len_w);
      sts.fit_eq     = (avail_w == len_w);
      sts.lim_ge_s   = (WW'(rd_limit) >= s_w);
      sts.first_le_e = (rd_first <= e_ff);
      sts.full       = (count_ff >= CW'(MAX_EXTENTS));
      sts.idx_eq_lo  = (idx_ff == lo_ff);
   end

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cmd.op)
         ffea_pkg::OP_INIT: begin
            wr_en   = 1'b1;
            wr_data = {AW'(0), MEM_AW};
         end
         ffea_pkg::OP_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff[XW-1:0];
         end
         ffea_pkg::OP_READ_PREV: begin
            rd_en   = 1'b1;
            rd_addr = idx_m1[XW-1:0];
         end
         ffea_pkg::OP_SHRINK: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[XW-1:0];
            wr_data = {first_plus_len, rd_limit};
         end
         ffea_pkg::OP_MERGE_WR: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[XW-1:0];
            wr_data = {nf_ff, nl_ff};
         end
         ffea_pkg::OP_DROP_WR: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[XW-1:0];
            wr_data = rd_data_ff;
         end
         ffea_pkg::OP_SHUP_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[XW-1:0];
            wr_data = rd_data_ff;
         end
         ffea_pkg::OP_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[XW-1:0];
            wr_data = {s_aw, e_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         extent_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= extent_ff[rd_addr];
      end
   end

   // next-state for pointers, request, status and response registers
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      dst_in        = dst_ff;
      lo_in         = lo_ff;
      op_in         = op_ff;
      s_in          = s_ff;
      len_in        = len_ff;
      e_in          = e_ff;
      nf_in         = nf_ff;
      nl_in         = nl_ff;
      grant_in      = grant_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      case (cmd.op)
         ffea_pkg::OP_INIT: begin
            count_in = CW'(1);
         end
         ffea_pkg::OP_LOAD: begin
            op_in     = req_opcode;
            s_in      = req_block_start;
            len_in    = req_block_length;
            e_in      = e_clip;
            idx_in    = '0;
            grant_in  = '0;
            status_in = ffea_pkg::ST_DONE;
         end
         ffea_pkg::OP_NEXT: begin
            idx_in = idx_ff + CW'(1);
         end
         ffea_pkg::OP_SHRINK: begin
            grant_in = rd_first;
         end
         ffea_pkg::OP_GRANT_DROP: begin
            grant_in = rd_first;
            dst_in   = idx_ff;
            idx_in   = idx_ff + CW'(1);
         end
         ffea_pkg::OP_MARK_LO: begin
            lo_in = idx_ff;
         end
         ffea_pkg::OP_MERGE_START: begin
            lo_in  = idx_ff;
            nf_in  = min_first;
            nl_in  = max_limit;
            idx_in = idx_ff + CW'(1);
         end
         ffea_pkg::OP_MERGE_EXT: begin
            nl_in  = max_limit;
            idx_in = idx_ff + CW'(1);
         end
         ffea_pkg::OP_MERGE_WR: begin
            dst_in = lo_ff + CW'(1);
         end
         ffea_pkg::OP_DROP_WR: begin
            dst_in = dst_ff + CW'(1);
            idx_in = idx_ff + CW'(1);
         end
         ffea_pkg::OP_DROP_END: begin
            // compacted table ends where the write pointer stopped
            count_in = dst_ff;
         end
         ffea_pkg::OP_INS_START: begin
            idx_in = count_ff;
         end
         ffea_pkg::OP_SHUP_WR: begin
            idx_in = idx_m1;
         end
         ffea_pkg::OP_INS_WR: begin
            count_in = count_ff + CW'(1);
         end
         ffea_pkg::OP_RSP_LOAD: begin
            rsp_status_in = status_ff;
            rsp_grant_in  = grant_w[ffea_pkg::GRANT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      dst_ff        <= dst_in;
      lo_ff         <= lo_in;
      op_ff         <= op_in;
      s_ff          <= s_in;
      len_ff        <= len_in;
      e_ff          <= e_in;
      nf_ff         <= nf_in;
      nl_ff         <= nl_in;
      grant_ff      <= grant_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_grant_ff;

endmodule

FILE: rtl/first_fit_extent_allocator.sv
`timescale 1ns / 1ps

// First-fit extent allocator with coalescing on free.
// req_chan carries one request per transfer: opcode (allocate / free), block_start
// and block_length. rsp_chan returns exactly one transfer per request: status
// (done, no fit, table full) and granted_start for a successful allocate.
// Requests are handled one at a time. req_chan is ready only in idle; a new
// request is taken while the previous response still sits in the output register.
// Work per request: a memory read, then an evaluate or move step, for each table
// entry visited, plus dispatch, write-back and response load. The extent memory
// is walked in address order, one entry at a time.
// No two requests overlap; req_chan reopens the cycle after the response loads.
// Reset: once reset releases, the controller first writes the whole-memory
// extent into entry 0; req_chan stays not ready while it does so.
// Stall: a response not taken holds in the output register; the next
// request then finishes its work and waits until that transfer completes.
module first_fit_extent_allocator #(
   parameter int MEM_SIZE    = ffea_pkg::MEM_SIZE_DEFAULT,
   parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ffea_req_if.sink   req_chan,
   ffea_rsp_if.source rsp_chan
);

   ffea_pkg::dp_cmd_type cmd;   // controller -> datapath micro-op
   ffea_pkg::dp_sts_type sts;   // datapath compare flags

   // sequencer: table walk, compaction, insert shift, response handoff
   ffea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // extent memory, count, scan pointers and response register
   ffea_dpath #(
      .MEM_SIZE    (MEM_SIZE),
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_chan.opcode),
      .req_block_start   (req_chan.block_start),
      .req_block_length  (req_chan.block_length),
      .rsp_status        (rsp_chan.status),
      .rsp_granted_start (rsp_chan.granted_start),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

FILE: rtl/ffea_checker.sv
`timescale 1ns / 1ps

module ffea_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ffea_pkg::STATUS_W-1:0] rsp_status,
   input logic [ffea_pkg::GRANT_W-1:0]  rsp_granted_start
);

   // held response must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_granted_start))
      else $error("response changed while stalled");

   // one request in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ffea_pkg::ST_DONE || rsp_status == ffea_pkg::ST_NOFIT
                     || rsp_status == ffea_pkg::ST_FULL))
      else $error("bad status code");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffea_pkg::ST_DONE |-> rsp_granted_start == '0)
      else $error("grant on failed request");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channels active after reset");

endmodule

bind first_fit_extent_allocator ffea_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_granted_start (rsp_chan.granted_start)
);
